// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the star wildcard matcher.
package swm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    localparam logic [7:0] STAR_BYTE = 8'd42;

    typedef struct packed {
        logic pattern_overflow;
        logic matched;
    } result_t;

endpackage

// ===== rtl/swm_closure.sv =====
// Parallel-prefix star closure of the reachable position set.
module swm_closure #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] set_in,
    input  logic [WIDTH-2:0] prop_in,
    output logic [WIDTH-1:0] closed_out
);

    localparam int LEVELS = $clog2(WIDTH);

    logic [WIDTH-1:0] g_stage [0:LEVELS];
    logic [WIDTH-1:0] p_stage [0:LEVELS];

    // position j inherits reachability from j-1 when pattern byte j-1 is a star
    always_comb begin
        g_stage[0] = set_in;
        p_stage[0] = {prop_in, 1'b0};
        for (int l = 0; l < LEVELS; l++) begin
            for (int j = 0; j < WIDTH; j++) begin
                if (j >= (1 << l)) begin
                    g_stage[l+1][j] = g_stage[l][j]
                                    | (p_stage[l][j] & g_stage[l][j-(1<<l)]);
                    p_stage[l+1][j] = p_stage[l][j] & p_stage[l][j-(1<<l)];
                end else begin
                    g_stage[l+1][j] = g_stage[l][j];
                    p_stage[l+1][j] = p_stage[l][j];
                end
            end
        end
    end

    assign closed_out = g_stage[LEVELS] | (p_stage[LEVELS] & '0);

endmodule

// ===== rtl/swm_out_buf.sv =====
// Two-entry result buffer: output register with a skid stage behind it.
module swm_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  swm_pkg::result_t  push_data,
    output logic              ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output swm_pkg::result_t  m_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    swm_pkg::result_t out_data_reg, out_data_next;
    swm_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            // advance: skid word first, else the new word
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            // hold: park the new word in the skid stage
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready    = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

endmodule

// ===== rtl/star_wildcard_matcher_top.sv =====
// Star-only glob matcher: pattern store, position-set update and result buffer.
// An end-of-name result is registered in the output register (or skid stage) before m_tvalid.
// Throughput: one word per cycle while s_tready is high; the position set is updated by a
// parallel-prefix star closure and a per-position byte compare.
// Two result words may wait on the output before s_tready falls.
// Reset clears length and overflow flag and resets the position set; stored bytes are not reset.
module star_wildcard_matcher_top #(
    parameter int PATTERN_MAX = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [7:0]             store_reg [0:PATTERN_MAX-1];
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [PATTERN_MAX:0]   reach_reg, reach_next;

    logic [PATTERN_MAX-1:0] prop;
    logic [PATTERN_MAX:0]   closed;
    logic [PATTERN_MAX:0]   step_set;
    logic                   accept;
    logic                   push;
    logic                   match_bit;
    swm_pkg::cmd_t          cmd;
    swm_pkg::result_t       push_data;
    swm_pkg::result_t       out_data;

    assign accept = s_tvalid && s_tready;
    assign cmd    = swm_pkg::cmd_t'(s_tuser);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            prop[i] = (store_reg[i] == swm_pkg::STAR_BYTE) && (LEN_W'(i) < len_reg);
        end
    end

    swm_closure #(
        .WIDTH (PATTERN_MAX + 1)
    ) u_closure (
        .set_in     (reach_reg),
        .prop_in    (prop),
        .closed_out (closed)
    );

    // star stays put, a matching literal advances one position
    always_comb begin
        step_set = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (closed[i] && (LEN_W'(i) < len_reg)) begin
                if (store_reg[i] == swm_pkg::STAR_BYTE) begin
                    step_set[i] = 1'b1;
                end else if (store_reg[i] == s_tdata) begin
                    step_set[i+1] = 1'b1;
                end
            end
        end
    end

    assign match_bit = closed[len_reg] && !ovf_reg;

    always_comb begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        reach_next = reach_reg;
        if (accept) begin
            unique case (cmd)
                swm_pkg::CMD_CLEAR: begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    reach_next = (PATTERN_MAX + 1)'(1);
                end
                swm_pkg::CMD_APPEND: begin
                    if (len_reg < LEN_W'(PATTERN_MAX)) begin
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                swm_pkg::CMD_NAME: begin
                    reach_next = step_set;
                end
                swm_pkg::CMD_END: begin
                    reach_next = (PATTERN_MAX + 1)'(1);
                end
                default: begin
                    reach_next = reach_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            reach_reg <= (PATTERN_MAX + 1)'(1);
        end else begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            reach_reg <= reach_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (accept && (cmd == swm_pkg::CMD_APPEND) && (len_reg == LEN_W'(i))) begin
                store_reg[i] <= s_tdata;
            end
        end
    end

    assign push                       = accept && (cmd == swm_pkg::CMD_END);
    assign push_data.matched          = match_bit;
    assign push_data.pattern_overflow = ovf_reg;

    swm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {6'b0, out_data.pattern_overflow, out_data.matched};

`ifndef ASSERT_OFF
    a_len_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_ovf_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == LEN_W'(PATTERN_MAX)))
        else $error("overflow flagged with room left");

    a_reach_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((reach_reg >> len_reg) >> 1) == '0)
        else $error("reachable position beyond pattern end");

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd == swm_pkg::CMD_CLEAR)) |=>
            (len_reg == '0) && !ovf_reg && (reach_reg == (PATTERN_MAX + 1)'(1)))
        else $error("clear did not restore pattern state");
`endif

endmodule

// ===== tb/tb_star_wildcard_matcher_top.sv =====
// Self-checking testbench for the star wildcard matcher: directed and random words, scoreboard.
module tb_star_wildcard_matcher_top;

    localparam int PATTERN_MAX = 32;
    localparam int RAND_WORDS  = 1850;
    localparam int STALL_LIMIT = 2000;

    class match_scoreboard;
        logic [7:0]           pattern_bytes [PATTERN_MAX];
        int unsigned          pattern_len;
        logic [PATTERN_MAX:0] reach;
        bit                   overflow;
        swm_pkg::result_t     pending_verdicts [$];
        int                   mismatches;

        function new();
            foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
            pattern_len = 0;
            reach       = (PATTERN_MAX + 1)'(1);
            overflow    = 1'b0;
            mismatches  = 0;
        endfunction

        function logic [PATTERN_MAX:0] close_stars(logic [PATTERN_MAX:0] set);
            for (int i = 0; i < pattern_len; i++) begin
                if (set[i] && pattern_bytes[i] == swm_pkg::STAR_BYTE) set[i + 1] = 1'b1;
            end
            return set;
        endfunction

        function void note_word(swm_pkg::cmd_t cmd, logic [7:0] char_byte);
            logic [PATTERN_MAX:0] cur;
            logic [PATTERN_MAX:0] nxt;
            swm_pkg::result_t     verdict;
            case (cmd)
                swm_pkg::CMD_CLEAR: begin
                    pattern_len = 0;
                    overflow    = 1'b0;
                    reach       = (PATTERN_MAX + 1)'(1);
                end
                swm_pkg::CMD_APPEND: begin
                    if (pattern_len < PATTERN_MAX) begin
                        pattern_bytes[pattern_len] = char_byte;
                        pattern_len++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                swm_pkg::CMD_NAME: begin
                    cur = close_stars(reach);
                    nxt = '0;
                    for (int i = 0; i < pattern_len; i++) begin
                        if (cur[i]) begin
                            if (pattern_bytes[i] == swm_pkg::STAR_BYTE) nxt[i] = 1'b1;
                            else if (pattern_bytes[i] == char_byte) nxt[i + 1] = 1'b1;
                        end
                    end
                    reach = nxt;
                end
                default: begin
                    cur = close_stars(reach);
                    verdict.matched          = !overflow && cur[pattern_len];
                    verdict.pattern_overflow = overflow;
                    pending_verdicts.push_back(verdict);
                    reach = (PATTERN_MAX + 1)'(1);
                end
            endcase
        endfunction

        function void check_result(logic [7:0] word);
            swm_pkg::result_t want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result word %h", word);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (word[0] !== want.matched) begin
                $error("matched: expected %0b, actual %0b", want.matched, word[0]);
                mismatches++;
            end
            if (word[1] !== want.pattern_overflow) begin
                $error("pattern_overflow: expected %0b, actual %0b",
                       want.pattern_overflow, word[1]);
                mismatches++;
            end
            if (word[7:2] !== 6'd0) begin
                $error("padding: expected 0, actual %0h", word[7:2]);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [1:0] s_tuser  = swm_pkg::CMD_CLEAR;
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;

    bit              calm = 1'b0;
    int              words_sent = 0;
    int              stall_cycles = 0;
    match_scoreboard sb;

    star_wildcard_matcher_top #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] char_byte
        .s_tuser (s_tuser),   // [1:0] command
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [0] matched, [1] pattern_overflow, [7:2] zero
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return "a";
            4, 5:       return "b";
            6:          return swm_pkg::STAR_BYTE;
            7:          return 8'h00;
            8:          return 8'hFF;
            default:    return 8'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_word(input swm_pkg::cmd_t cmd, input logic [7:0] char_byte);
        while (!calm && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= char_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(cmd, char_byte);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_verdicts.size() != 0) @(negedge aclk);
    endtask

    task automatic run_sequence(input bit force_overflow);
        logic [7:0] pat_q [$];
        logic [7:0] name_q [$];
        logic [7:0] b;
        int         plen_sel;
        int         n_names;
        send_word(swm_pkg::CMD_CLEAR, 8'($urandom));
        if (force_overflow) begin
            plen_sel = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 8);
        end else begin
            case ($urandom_range(0, 19))
                0:       plen_sel = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 8);
                1, 2:    plen_sel = $urandom_range(17, PATTERN_MAX);
                default: plen_sel = $urandom_range(0, 8);
            endcase
        end
        for (int i = 0; i < plen_sel; i++) begin
            b = ($urandom_range(0, 9) < 3) ? swm_pkg::STAR_BYTE : pick_byte();
            pat_q.push_back(b);
            send_word(swm_pkg::CMD_APPEND, b);
        end
        n_names = $urandom_range(1, 4);
        repeat (n_names) begin
            name_q.delete();
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, 6)) name_q.push_back(pick_byte());
            end else begin
                for (int j = 0; j < pat_q.size() && j < PATTERN_MAX; j++) begin
                    if (pat_q[j] == swm_pkg::STAR_BYTE) begin
                        repeat ($urandom_range(0, 3)) name_q.push_back(pick_byte());
                    end else begin
                        name_q.push_back(pat_q[j]);
                    end
                end
                if ($urandom_range(0, 4) == 0 && name_q.size() > 0)
                    name_q[$urandom_range(0, name_q.size() - 1)] = pick_byte();
            end
            foreach (name_q[k]) begin
                case ($urandom_range(0, 99))
                    0, 1, 2, 3: send_word(swm_pkg::CMD_APPEND, pick_byte());
                    4:          send_word(swm_pkg::cmd_t'($urandom_range(0, 3)),
                                          8'($urandom));
                    default:    ;
                endcase
                send_word(swm_pkg::CMD_NAME, name_q[k]);
            end
            send_word(swm_pkg::CMD_END, 8'($urandom));
        end
    endtask

    initial begin
        int seq_count;
        int target;
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(swm_pkg::CMD_END,    8'h00);
        send_word(swm_pkg::CMD_APPEND, swm_pkg::STAR_BYTE);
        send_word(swm_pkg::CMD_END,    8'hFF);
        send_word(swm_pkg::CMD_NAME,   8'h00);
        send_word(swm_pkg::CMD_END,    8'h00);
        send_word(swm_pkg::CMD_CLEAR,  8'hFF);
        send_word(swm_pkg::CMD_APPEND, 8'h00);
        send_word(swm_pkg::CMD_APPEND, 8'hFF);
        send_word(swm_pkg::CMD_NAME,   8'h00);
        send_word(swm_pkg::CMD_NAME,   8'hFF);
        send_word(swm_pkg::CMD_END,    8'hFF);
        send_word(swm_pkg::CMD_NAME,   8'hFF);
        send_word(swm_pkg::CMD_END,    8'h00);
        send_word(swm_pkg::CMD_CLEAR,  8'h00);
        send_word(swm_pkg::CMD_APPEND, "a");
        send_word(swm_pkg::CMD_NAME,   "a");
        send_word(swm_pkg::CMD_APPEND, swm_pkg::STAR_BYTE);
        send_word(swm_pkg::CMD_NAME,   "z");
        send_word(swm_pkg::CMD_END,    8'h55);
        send_word(swm_pkg::CMD_NAME,   swm_pkg::STAR_BYTE);
        send_word(swm_pkg::CMD_END,    8'hAA);
        drain_results();

        seq_count = 0;
        target    = words_sent + RAND_WORDS;
        while (words_sent < target) begin
            calm = (words_sent >= 700 && words_sent < 1000);
            run_sequence(seq_count == 0);
            seq_count++;
            if (seq_count % 25 == 0) drain_results();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== star_wildcard_matcher_top.f =====
rtl/swm_pkg.sv
rtl/swm_closure.sv
rtl/swm_out_buf.sv
rtl/star_wildcard_matcher_top.sv
tb/tb_star_wildcard_matcher_top.sv
